[src/odo_pkg.sv]
`timescale 1ns / 1ps
package odo_pkg;

    localparam int DIV_W = 26;
    localparam int CNT_W = 5;

    localparam logic [2:0] REG_TRACK_WIDTH = 3'd0;
    localparam logic [2:0] REG_EMA_ALPHA   = 3'd1;
    localparam logic [2:0] REG_MAX_WHEEL   = 3'd2;
    localparam logic [2:0] REG_MAX_LINEAR  = 3'd3;
    localparam logic [2:0] REG_MAX_STEP    = 3'd4;

    localparam logic [15:0] RST_TRACK_WIDTH = 16'd300;
    localparam logic [16:0] RST_EMA_ALPHA   = 17'd13107;
    localparam logic [14:0] RST_MAX_WHEEL   = 15'd20480;
    localparam logic [14:0] RST_MAX_LINEAR  = 15'd12288;
    localparam logic [15:0] RST_MAX_STEP    = 16'd50000;

    localparam logic [16:0] ALPHA_ONE  = 17'd65536;
    localparam logic [9:0]  RATE_SCALE = 10'd1000;

    localparam logic signed [35:0] HALF_TURN = 36'sd12867963509;
    localparam logic signed [35:0] FULL_TURN = 36'sd25735927019;
    localparam logic signed [35:0] WRAP_HIGH = 36'sd12867963510;

    typedef struct packed {
        logic load_p;
        logic load_q;
        logic commit;
    } lane_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LANE_P,
        ST_LANE_Q,
        ST_LANE_S,
        ST_MERGE,
        ST_SCALE,
        ST_DIV,
        ST_DIV_WAIT,
        ST_ANGLE,
        ST_PRODUCT,
        ST_ACCUM,
        ST_EMIT
    } odo_state_t;

endpackage

[src/odo_wheel_lane.sv]
`timescale 1ns / 1ps
module odo_wheel_lane
    import odo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lane_ctrl_t         ctrl,
    input  logic signed [15:0] speed,
    input  logic [14:0]        wheel_max,
    input  logic [16:0]        alpha,
    output logic signed [31:0] smoothed
);

    logic signed [16:0] limit_pos;
    logic signed [16:0] limit_neg;
    logic signed [15:0] clamped;
    logic [16:0]        keep_w;
    logic signed [50:0] sum;

    logic signed [15:0] vclamp_reg;
    logic signed [49:0] p_reg;
    logic signed [33:0] q_reg;
    logic signed [31:0] smoothed_reg;

    always_comb
    begin
        limit_pos = $signed({2'b00, wheel_max});
        limit_neg = -limit_pos;
        if ($signed({speed[15], speed}) > limit_pos)
        begin
            clamped = limit_pos[15:0];
        end
        else if ($signed({speed[15], speed}) < limit_neg)
        begin
            clamped = limit_neg[15:0];
        end
        else
        begin
            clamped = speed;
        end
        keep_w = ALPHA_ONE - alpha;
        sum = 51'(p_reg) + (51'(q_reg) <<< 16);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_p)
        begin
            vclamp_reg <= clamped;
            p_reg      <= $signed({1'b0, keep_w}) * smoothed_reg;
        end
        if (ctrl.load_q)
        begin
            q_reg <= $signed({1'b0, alpha}) * vclamp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothed_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            smoothed_reg <= sum[47:16];
        end
    end

    assign smoothed = smoothed_reg;

endmodule

[src/odo_rate_div.sv]
`timescale 1ns / 1ps
module odo_rate_div
    import odo_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [15:0]      divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);

    logic [16:0]      trial;
    logic             fits;

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [15:0]      rem_reg;
    logic [15:0]      div_reg;
    logic [DIV_W-1:0] quot_reg;

    always_comb
    begin
        trial = {rem_reg, quot_reg[DIV_W-1]};
        fits  = trial >= {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            busy_reg <= cnt_reg != CNT_W'(1);
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            div_reg  <= divisor;
            quot_reg <= dividend;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= 16'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_reg <= trial[15:0];
            end
            quot_reg <= {quot_reg[DIV_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

[src/diff_drive_odometry_step.sv]
`timescale 1ns / 1ps
// Differential-drive odometry step.
// Input channel (in_valid/in_ready) carries one tick per beat: time step, two
// wheel speeds with health bits, gyro rate with its health bit. Output channel
// (out_valid/out_ready) returns one beat per tick: linear speed, angular speed,
// total distance, heading and the updated flag.
// Two wheel lanes clamp and smooth the wheel speeds side by side in load_p,
// load_q and commit steps, two multipliers per lane; a merge stage then forms
// linear speed and the speed difference; later states form angular speed and
// the distance and heading increments. A valid gyro skips the divider, else
// the encoder fallback runs the restoring divider; a rejected tick goes
// straight to the output. A new beat is taken once the previous tick has
// moved into the output register, so one tick is processed at a time.
// The APB port holds the five configuration registers at byte addresses
// 0, 4, 8, 12 and 16; pready is always high.
// Reset clears smoothed speeds, last speeds, distance and heading, and loads
// the configuration defaults. While the receiver stalls the output register
// holds its beat; a finished tick waits until the output register frees.
module diff_drive_odometry_step
    import odo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        step_us,
    input  logic signed [15:0] left_speed,
    input  logic signed [15:0] right_speed,
    input  logic               left_valid,
    input  logic               right_valid,
    input  logic signed [15:0] gyro_rate,
    input  logic               gyro_valid,

    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] linear_speed,
    output logic signed [15:0] angular_speed,
    output logic signed [63:0] total_distance,
    output logic signed [34:0] heading,
    output logic               updated
);

    logic [15:0] track_width_reg;
    logic [16:0] ema_alpha_reg;
    logic [14:0] max_wheel_reg;
    logic [14:0] max_linear_reg;
    logic [15:0] max_step_reg;

    logic        cfg_write;
    logic [16:0] alpha_eff;
    logic [15:0] track_eff;

    odo_state_t  state_reg;
    odo_state_t  state_next;

    lane_ctrl_t  lane_ctrl;
    logic        div_start;
    logic        div_busy;
    logic [DIV_W-1:0] div_quot;
    logic        out_load;
    logic        in_fire;
    logic        bad_tick;

    logic signed [31:0] left_smoothed;
    logic signed [31:0] right_smoothed;

    logic [15:0]        step_reg;
    logic signed [15:0] vl_reg;
    logic signed [15:0] vr_reg;
    logic signed [15:0] gyro_reg;
    logic               gv_reg;
    logic               bad_reg;
    logic signed [15:0] lin_reg;
    logic [31:0]        diff_mag_reg;
    logic               diff_neg_reg;
    logic [41:0]        prod_reg;
    logic signed [15:0] ang_reg;
    logic signed [31:0] dinc_reg;
    logic signed [31:0] hinc_reg;

    logic signed [15:0] last_linear_reg;
    logic signed [15:0] last_angular_reg;
    logic signed [63:0] distance_reg;
    logic signed [35:0] heading_reg;

    logic               out_valid_reg;
    logic signed [15:0] linear_speed_reg;
    logic signed [15:0] angular_speed_reg;
    logic signed [63:0] total_distance_reg;
    logic signed [34:0] heading_out_reg;
    logic               updated_reg;

    logic signed [33:0] lin_sum;
    logic signed [16:0] lin_raw;
    logic signed [16:0] lmax_pos;
    logic signed [15:0] lin_clamped;
    logic signed [32:0] diff;
    logic [31:0]        diff_mag;
    logic signed [15:0] enc_rate;
    logic signed [32:0] dinc_full;
    logic signed [32:0] hinc_full;
    logic signed [64:0] dist_sum;
    logic signed [63:0] dist_new;
    logic signed [36:0] head_sum;
    logic signed [36:0] head_wrap;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign alpha_eff = (ema_alpha_reg > ALPHA_ONE) ? ALPHA_ONE : ema_alpha_reg;
    assign track_eff = (track_width_reg == 16'd0) ? 16'd1 : track_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_width_reg <= RST_TRACK_WIDTH;
            ema_alpha_reg   <= RST_EMA_ALPHA;
            max_wheel_reg   <= RST_MAX_WHEEL;
            max_linear_reg  <= RST_MAX_LINEAR;
            max_step_reg    <= RST_MAX_STEP;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_TRACK_WIDTH: track_width_reg <= pwdata[15:0];
                REG_EMA_ALPHA:   ema_alpha_reg   <= pwdata[16:0];
                REG_MAX_WHEEL:   max_wheel_reg   <= pwdata[14:0];
                REG_MAX_LINEAR:  max_linear_reg  <= pwdata[14:0];
                REG_MAX_STEP:    max_step_reg    <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_TRACK_WIDTH: prdata = {16'd0, track_width_reg};
            REG_EMA_ALPHA:   prdata = {15'd0, ema_alpha_reg};
            REG_MAX_WHEEL:   prdata = {17'd0, max_wheel_reg};
            REG_MAX_LINEAR:  prdata = {17'd0, max_linear_reg};
            REG_MAX_STEP:    prdata = {16'd0, max_step_reg};
            default:         prdata = '0;
        endcase
    end

    assign in_fire  = in_valid && in_ready;
    assign bad_tick = (step_us == 16'd0) || (step_us > max_step_reg)
                      || !left_valid || !right_valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_valid) state_next = bad_tick ? ST_EMIT : ST_LANE_P;
            ST_LANE_P:   state_next = ST_LANE_Q;
            ST_LANE_Q:   state_next = ST_LANE_S;
            ST_LANE_S:   state_next = ST_MERGE;
            ST_MERGE:    state_next = gv_reg ? ST_ANGLE : ST_SCALE;
            ST_SCALE:    state_next = ST_DIV;
            ST_DIV:      state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (!div_busy) state_next = ST_ANGLE;
            ST_ANGLE:    state_next = ST_PRODUCT;
            ST_PRODUCT:  state_next = ST_ACCUM;
            ST_ACCUM:    state_next = ST_EMIT;
            ST_EMIT:     if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready         = 1'b0;
        lane_ctrl        = '0;
        div_start        = 1'b0;
        out_load         = 1'b0;
        case (state_reg)
            ST_IDLE:   in_ready         = 1'b1;
            ST_LANE_P: lane_ctrl.load_p = 1'b1;
            ST_LANE_Q: lane_ctrl.load_q = 1'b1;
            ST_LANE_S: lane_ctrl.commit = 1'b1;
            ST_DIV:    div_start        = 1'b1;
            ST_EMIT:   out_load         = !out_valid_reg || out_ready;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    odo_wheel_lane u_left_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (lane_ctrl),
        .speed     (vl_reg),
        .wheel_max (max_wheel_reg),
        .alpha     (alpha_eff),
        .smoothed  (left_smoothed)
    );

    odo_wheel_lane u_right_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (lane_ctrl),
        .speed     (vr_reg),
        .wheel_max (max_wheel_reg),
        .alpha     (alpha_eff),
        .smoothed  (right_smoothed)
    );

    odo_rate_div u_rate_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg[41:16]),
        .divisor  (track_eff),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    always_comb
    begin
        lin_sum  = 34'(left_smoothed) + 34'(right_smoothed) + 34'sd65536;
        lin_raw  = lin_sum[33:17];
        lmax_pos = $signed({2'b00, max_linear_reg});
        if (lin_raw > lmax_pos)
        begin
            lin_clamped = lmax_pos[15:0];
        end
        else if (lin_raw < -lmax_pos)
        begin
            lin_clamped = 16'(-lmax_pos);
        end
        else
        begin
            lin_clamped = lin_raw[15:0];
        end

        diff     = 33'(right_smoothed) - 33'(left_smoothed);
        diff_mag = diff[32] ? 32'(-diff) : diff[31:0];

        if (diff_neg_reg)
        begin
            enc_rate = (div_quot > DIV_W'(32768)) ? 16'sh8000 : 16'(-div_quot[15:0]);
        end
        else
        begin
            enc_rate = (div_quot > DIV_W'(32767)) ? 16'sd32767 : $signed(div_quot[15:0]);
        end

        dinc_full = lin_reg * $signed({1'b0, step_reg});
        hinc_full = ang_reg * $signed({1'b0, step_reg});

        dist_sum = 65'(distance_reg) + 65'(dinc_reg);
        if (!dist_sum[64] && dist_sum[63])
        begin
            dist_new = {1'b0, {63{1'b1}}};
        end
        else if (dist_sum[64] && !dist_sum[63])
        begin
            dist_new = {1'b1, 63'd0};
        end
        else
        begin
            dist_new = dist_sum[63:0];
        end

        head_sum = 37'(heading_reg) + 37'(hinc_reg);
        if (head_sum >= 37'(WRAP_HIGH))
        begin
            head_wrap = head_sum - 37'(FULL_TURN);
        end
        else if (head_sum < -37'(HALF_TURN))
        begin
            head_wrap = head_sum + 37'(FULL_TURN);
        end
        else
        begin
            head_wrap = head_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            step_reg <= step_us;
            vl_reg   <= left_speed;
            vr_reg   <= right_speed;
            gyro_reg <= gyro_rate;
            gv_reg   <= gyro_valid;
            bad_reg  <= bad_tick;
        end
        if (state_reg == ST_MERGE)
        begin
            lin_reg      <= lin_clamped;
            diff_mag_reg <= diff_mag;
            diff_neg_reg <= diff[32];
        end
        if (state_reg == ST_SCALE)
        begin
            prod_reg <= diff_mag_reg * RATE_SCALE;
        end
        if (state_reg == ST_ANGLE)
        begin
            ang_reg <= gv_reg ? gyro_reg : enc_rate;
        end
        if (state_reg == ST_PRODUCT)
        begin
            dinc_reg <= dinc_full[31:0];
            hinc_reg <= hinc_full[31:0];
        end
        if (out_load)
        begin
            linear_speed_reg   <= last_linear_reg;
            angular_speed_reg  <= last_angular_reg;
            total_distance_reg <= distance_reg;
            heading_out_reg    <= heading_reg[34:0];
            updated_reg        <= !bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_linear_reg  <= '0;
            last_angular_reg <= '0;
            distance_reg     <= '0;
            heading_reg      <= '0;
        end
        else if (state_reg == ST_ACCUM)
        begin
            last_linear_reg  <= lin_reg;
            last_angular_reg <= ang_reg;
            distance_reg     <= dist_new;
            heading_reg      <= head_wrap[35:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign linear_speed   = linear_speed_reg;
    assign angular_speed  = angular_speed_reg;
    assign total_distance = total_distance_reg;
    assign heading        = heading_out_reg;
    assign updated        = updated_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCUM) |-> !bad_reg)
        else $error("rejected tick reached accumulate");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_busy)
        else $error("divider busy while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != ST_IDLE))
        else $error("accepted beat did not start processing");

    assert property (@(posedge clk) disable iff (!rst_n)
        (heading_reg >= -HALF_TURN) && (heading_reg < WRAP_HIGH))
        else $error("heading out of wrap range");

endmodule
